### hdl/cmta_pkg.sv
package cmta_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned COMPONENT_BITS_DEF = 16;
  localparam int unsigned MAX_FACE_SIZE_DEF  = 4096;

  // Fixed field widths
  localparam int unsigned SIZE_REG_W = 13;
  localparam int unsigned TEXEL_W    = 12;
  localparam int unsigned FACE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 1;

  // Depth of the queue between the classifier and the divider pipeline
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [SIZE_REG_W-1:0] SIZE_RESET = SIZE_REG_W'(512);

  typedef enum logic [FACE_W-1:0] {
    FACE_XP = 3'd0,
    FACE_XN = 3'd1,
    FACE_YP = 3'd2,
    FACE_YN = 3'd3,
    FACE_ZP = 3'd4,
    FACE_ZN = 3'd5
  } face_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FACE_WIDTH  = 1'b0,
    CFG_FACE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Bits needed to hold an effective face size (and a quotient) up to max_size
  function automatic int unsigned size_bits(int unsigned max_size);
    return $clog2(max_size + 1);
  endfunction

  // Width of one classified item: face, zero flag, column, row, magnitude, sizes
  function automatic int unsigned item_bits(int unsigned cb, int unsigned sw);
    return FACE_W + 1 + 3 * cb + 2 * sw;
  endfunction

endpackage

### hdl/cmta_intf.sv
interface cmta_dir_if #(
  parameter int unsigned CB = cmta_pkg::COMPONENT_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CB-1:0] dir_x;
  logic signed [CB-1:0] dir_y;
  logic signed [CB-1:0] dir_z;

  modport source (output valid, dir_x, dir_y, dir_z, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

interface cmta_res_if;
  logic                           valid;
  logic                           ready;
  logic [cmta_pkg::FACE_W-1:0]    face;
  logic [cmta_pkg::TEXEL_W-1:0]   texel_x;
  logic [cmta_pkg::TEXEL_W-1:0]   texel_y;
  logic                           zero_dir;

  modport source (output valid, face, texel_x, texel_y, zero_dir, input ready);
  modport sink   (input valid, face, texel_x, texel_y, zero_dir, output ready);
endinterface

interface cmta_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cmta_pkg::CFG_IDX_W-1:0]    index;
  logic [cmta_pkg::SIZE_REG_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/cmta_front.sv
module cmta_front #(
  parameter int unsigned COMPONENT_BITS = cmta_pkg::COMPONENT_BITS_DEF,
  parameter int unsigned MAX_FACE_SIZE  = cmta_pkg::MAX_FACE_SIZE_DEF,
  localparam int unsigned SW = cmta_pkg::size_bits(MAX_FACE_SIZE),
  localparam int unsigned IW = cmta_pkg::item_bits(COMPONENT_BITS, SW)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  cmta_dir_if.sink       dir_i,
  cmta_cfg_if.sink       cfg_i,
  output logic           item_valid_o,
  input  logic           item_ready_i,
  output logic [IW-1:0]  item_o
);

  localparam int unsigned CB = COMPONENT_BITS;

  typedef struct packed {
    logic [cmta_pkg::FACE_W-1:0] face;
    logic                        zero;
    logic signed [CB-1:0]        col;
    logic signed [CB-1:0]        row;
    logic [CB-1:0]               mag;
    logic [SW-1:0]               w;
    logic [SW-1:0]               h;
  } item_t;

  logic [cmta_pkg::SIZE_REG_W-1:0] width_q, height_q;
  logic [CB-1:0] ax, ay, az;
  logic          x_pos, y_pos, z_pos;
  logic [SW-1:0] w_eff, h_eff;
  item_t         item_d, item_q;
  logic          vld_d, vld_q;
  logic          take;

  // Size registers; the user must write them only while the block is idle, which the block itself does not enforce
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= cmta_pkg::SIZE_RESET;
      height_q <= cmta_pkg::SIZE_RESET;
    end else if (cfg_i.valid) begin
      unique case (cmta_pkg::cfg_reg_e'(cfg_i.index))
        cmta_pkg::CFG_FACE_WIDTH:  width_q  <= cfg_i.data;
        cmta_pkg::CFG_FACE_HEIGHT: height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Clamp sizes into 1..MAX_FACE_SIZE
  always_comb begin
    if (width_q == '0) begin
      w_eff = SW'(1);
    end else if (32'(width_q) > MAX_FACE_SIZE) begin
      w_eff = SW'(MAX_FACE_SIZE);
    end else begin
      w_eff = SW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = SW'(1);
    end else if (32'(height_q) > MAX_FACE_SIZE) begin
      h_eff = SW'(MAX_FACE_SIZE);
    end else begin
      h_eff = SW'(height_q);
    end
  end

  // Magnitudes and signs of the components
  assign ax = dir_i.dir_x[CB-1] ? (~$unsigned(dir_i.dir_x) + 1'b1) : $unsigned(dir_i.dir_x);
  assign ay = dir_i.dir_y[CB-1] ? (~$unsigned(dir_i.dir_y) + 1'b1) : $unsigned(dir_i.dir_y);
  assign az = dir_i.dir_z[CB-1] ? (~$unsigned(dir_i.dir_z) + 1'b1) : $unsigned(dir_i.dir_z);
  assign x_pos = !dir_i.dir_x[CB-1] && (dir_i.dir_x != '0);
  assign y_pos = !dir_i.dir_y[CB-1] && (dir_i.dir_y != '0);
  assign z_pos = !dir_i.dir_z[CB-1] && (dir_i.dir_z != '0);

  // Pick the major axis; ties fall to the later axis
  always_comb begin
    item_d.zero = (ax == '0) && (ay == '0) && (az == '0);
    item_d.w    = w_eff;
    item_d.h    = h_eff;
    priority if ((ax > ay) && (ax > az)) begin
      item_d.face = x_pos ? cmta_pkg::FACE_XP : cmta_pkg::FACE_XN;
      item_d.col  = dir_i.dir_z;
      item_d.row  = dir_i.dir_y;
      item_d.mag  = ax;
    end else if (ay > az) begin
      item_d.face = y_pos ? cmta_pkg::FACE_YP : cmta_pkg::FACE_YN;
      item_d.col  = dir_i.dir_x;
      item_d.row  = dir_i.dir_z;
      item_d.mag  = ay;
    end else begin
      item_d.face = z_pos ? cmta_pkg::FACE_ZP : cmta_pkg::FACE_ZN;
      item_d.col  = dir_i.dir_x;
      item_d.row  = dir_i.dir_y;
      item_d.mag  = az;
    end
  end

  // Hold one classified beat until the queue takes it
  assign dir_i.ready = !vld_q || item_ready_i;
  assign take        = dir_i.valid && dir_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (item_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = vld_q;
  assign item_o       = item_q;

endmodule

### hdl/cmta_fifo.sv
module cmta_fifo #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = cmta_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output logic [DATA_W-1:0] rd_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              push, pop;

  assign wr_ready_o = (cnt_q != CW'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem[rd_ptr_q];

  // Advance pointers with wrap at DEPTH
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### hdl/cmta_back.sv
module cmta_back #(
  parameter int unsigned COMPONENT_BITS = cmta_pkg::COMPONENT_BITS_DEF,
  parameter int unsigned MAX_FACE_SIZE  = cmta_pkg::MAX_FACE_SIZE_DEF,
  localparam int unsigned SW = cmta_pkg::size_bits(MAX_FACE_SIZE),
  localparam int unsigned IW = cmta_pkg::item_bits(COMPONENT_BITS, SW)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  output logic           item_ready_o,
  input  logic [IW-1:0]  item_i,
  cmta_res_if.source     res_o
);

  localparam int unsigned CB = COMPONENT_BITS;
  localparam int unsigned DW = CB + 1;        // divisor 2m
  localparam int unsigned NW = CB + 1 + SW;   // numerator (c + m) * size
  localparam int unsigned QB = SW;            // quotient bits, one per stage

  typedef struct packed {
    logic [cmta_pkg::FACE_W-1:0] face;
    logic                        zero;
    logic signed [CB-1:0]        col;
    logic signed [CB-1:0]        row;
    logic [CB-1:0]               mag;
    logic [SW-1:0]               w;
    logic [SW-1:0]               h;
  } item_t;

  typedef struct packed {
    logic [cmta_pkg::FACE_W-1:0] face;
    logic                        zero;
    logic [NW-1:0]               rem_x;
    logic [NW-1:0]               rem_y;
    logic [DW-1:0]               div;
    logic [SW-1:0]               quo_x;
    logic [SW-1:0]               quo_y;
    logic [SW-1:0]               w;
    logic [SW-1:0]               h;
  } stage_t;

  item_t             itm;
  logic [CB:0]       sum_col, sum_row;
  stage_t            st_d [QB+1];
  stage_t            st_q [QB+1];
  logic [QB:0]       vld_d, vld_q;
  logic [QB+1:0]     adv;
  logic [SW-1:0]     tx, ty;
  logic              out_vld_q, out_vld_d;
  logic [cmta_pkg::FACE_W-1:0]  out_face_q;
  logic [cmta_pkg::TEXEL_W-1:0] out_tx_q, out_ty_q;
  logic                         out_zero_q;

  assign itm = item_t'(item_i);

  // Stall chain: a stage moves when empty or when the next one moves
  always_comb begin
    adv[QB+1] = !out_vld_q || res_o.ready;
    for (int k = QB; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign item_ready_o = adv[0];

  // Stage 0 sums: c + m lies in 0..2m, so the low CB+1 bits are exact
  assign sum_col = {itm.col[CB-1], itm.col} + {1'b0, itm.mag};
  assign sum_row = {itm.row[CB-1], itm.row} + {1'b0, itm.mag};

  // Stage 0 forms numerators and divisor; later stages run a restoring
  // division, one quotient bit per stage, most significant first
  always_comb begin
    logic [NW-1:0] sh;
    st_d[0].face  = itm.face;
    st_d[0].zero  = itm.zero;
    st_d[0].rem_x = NW'(sum_col) * NW'(itm.w);
    st_d[0].rem_y = NW'(sum_row) * NW'(itm.h);
    st_d[0].div   = {itm.mag, 1'b0};
    st_d[0].quo_x = '0;
    st_d[0].quo_y = '0;
    st_d[0].w     = itm.w;
    st_d[0].h     = itm.h;
    for (int k = 1; k <= QB; k++) begin
      st_d[k] = st_q[k-1];
      sh      = NW'(st_q[k-1].div) << (QB - k);
      if (st_q[k-1].rem_x >= sh) begin
        st_d[k].rem_x = st_q[k-1].rem_x - sh;
        st_d[k].quo_x = st_q[k-1].quo_x | (SW'(1) << (QB - k));
      end
      if (st_q[k-1].rem_y >= sh) begin
        st_d[k].rem_y = st_q[k-1].rem_y - sh;
        st_d[k].quo_y = st_q[k-1].quo_y | (SW'(1) << (QB - k));
      end
    end
  end

  always_comb begin
    vld_d[0] = adv[0] ? item_valid_i : vld_q[0];
    for (int k = 1; k <= QB; k++) begin
      vld_d[k] = adv[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= QB; k++) begin
      if (adv[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // Clamp a quotient equal to the size down to size - 1
  assign tx = (st_q[QB].quo_x >= st_q[QB].w) ? st_q[QB].w - 1'b1 : st_q[QB].quo_x;
  assign ty = (st_q[QB].quo_y >= st_q[QB].h) ? st_q[QB].h - 1'b1 : st_q[QB].quo_y;

  // Output register; zero vector forces coordinates to zero
  assign out_vld_d = adv[QB+1] ? vld_q[QB] : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[QB+1]) begin
      out_face_q <= st_q[QB].face;
      out_zero_q <= st_q[QB].zero;
      out_tx_q   <= st_q[QB].zero ? '0 : cmta_pkg::TEXEL_W'(tx);
      out_ty_q   <= st_q[QB].zero ? '0 : cmta_pkg::TEXEL_W'(ty);
    end
  end

  assign res_o.valid    = out_vld_q;
  assign res_o.face     = out_face_q;
  assign res_o.texel_x  = out_tx_q;
  assign res_o.texel_y  = out_ty_q;
  assign res_o.zero_dir = out_zero_q;

endmodule

### hdl/cube_map_texel_address.sv
// Channel | Dir | Payload                                  | Beat taken when
// dir_i   | in  | dir_x, dir_y, dir_z (signed components)  | valid && ready
// res_o   | out | face, texel_x, texel_y, zero_dir         | valid && ready
// cfg_i   | in  | index (0 face_width, 1 face_height), data | valid && ready
//
// Throughput: one direction per cycle, sustained while res_o.ready stays high.
// Path: a direction is registered in the classifier, passes the queue and the
//   restoring divider, which resolves one quotient bit per pipeline stage, and
//   leaves through the output register.
// Reset: clears all valid bits and sets both face sizes to 512.
// Stalls: a four-beat queue sits between the classifier and the divider
//   pipeline; the pipeline fills its bubbles while the output is held.
module cube_map_texel_address #(
  parameter int unsigned COMPONENT_BITS = cmta_pkg::COMPONENT_BITS_DEF,
  parameter int unsigned MAX_FACE_SIZE  = cmta_pkg::MAX_FACE_SIZE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cmta_dir_if.sink    dir_i,
  cmta_res_if.source  res_o,
  cmta_cfg_if.sink    cfg_i
);

  localparam int unsigned SW = cmta_pkg::size_bits(MAX_FACE_SIZE);
  localparam int unsigned IW = cmta_pkg::item_bits(COMPONENT_BITS, SW);

  logic          fr_valid, fr_ready;
  logic [IW-1:0] fr_item;
  logic          bk_valid, bk_ready;
  logic [IW-1:0] bk_item;

  // Classify and pick the face
  cmta_front #(
    .COMPONENT_BITS (COMPONENT_BITS),
    .MAX_FACE_SIZE  (MAX_FACE_SIZE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dir_i        (dir_i),
    .cfg_i        (cfg_i),
    .item_valid_o (fr_valid),
    .item_ready_i (fr_ready),
    .item_o       (fr_item)
  );

  // Decouple front and back
  cmta_fifo #(
    .DATA_W (IW),
    .DEPTH  (cmta_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  (fr_item),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_data_o  (bk_item)
  );

  // Scale and divide into texel coordinates
  cmta_back #(
    .COMPONENT_BITS (COMPONENT_BITS),
    .MAX_FACE_SIZE  (MAX_FACE_SIZE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (bk_valid),
    .item_ready_o (bk_ready),
    .item_i       (bk_item),
    .res_o        (res_o)
  );

endmodule

### hdl/cmta_checker.sv
module cmta_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [cmta_pkg::FACE_W-1:0]    face_i,
  input logic [cmta_pkg::TEXEL_W-1:0]   texel_x_i,
  input logic [cmta_pkg::TEXEL_W-1:0]   texel_y_i,
  input logic                           zero_dir_i,
  input logic                           cfg_ready_i
);

  // A held result beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(face_i) && $stable(texel_x_i)
      && $stable(texel_y_i) && $stable(zero_dir_i))
    else $error("result beat changed while stalled");

  // A zero vector lands on the minus z face at the origin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && zero_dir_i |->
      face_i == cmta_pkg::FACE_ZN && texel_x_i == '0 && texel_y_i == '0)
    else $error("zero vector result malformed");

  // Size writes are never back-pressured
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_i)
    else $error("config port not ready");

endmodule

bind cube_map_texel_address cmta_checker u_cmta_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .face_i      (res_o.face),
  .texel_x_i   (res_o.texel_x),
  .texel_y_i   (res_o.texel_y),
  .zero_dir_i  (res_o.zero_dir),
  .cfg_ready_i (cfg_i.ready)
);

### tb/tb_top.sv
module tb_top;

  localparam int LAT_CYC   = $clog2(cmta_pkg::MAX_FACE_SIZE_DEF + 1) + 4;
  localparam int LIMIT_CYC = 200000;
  localparam int HOLD_LEN  = 80;
  localparam int RAND_ITEMS = 180;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } dir_t;

  typedef struct packed {
    logic [cmta_pkg::FACE_W-1:0]  face;
    logic [cmta_pkg::TEXEL_W-1:0] tx;
    logic [cmta_pkg::TEXEL_W-1:0] ty;
    logic                         zero;
  } texel_res_t;

  logic clk;
  logic rst_n;

  cmta_dir_if #(.CB(16)) dir_if ();
  cmta_res_if            res_if ();
  cmta_cfg_if            cfg_if ();

  cube_map_texel_address dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .dir_i  (dir_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Shadow of the face size registers
  logic [cmta_pkg::SIZE_REG_W-1:0] width_reg;
  logic [cmta_pkg::SIZE_REG_W-1:0] height_reg;

  dir_t       dir_pending [$];
  texel_res_t texel_due [$];

  int tx_idle_pct;
  int rx_idle_pct;
  int dir_beats;
  int hold_left;
  int hold_next;
  int err_cnt;
  int cycles;

  always #1 clk = ~clk;

  // Clamp a size register to the usable range
  function automatic longint fit_size(logic [cmta_pkg::SIZE_REG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > cmta_pkg::MAX_FACE_SIZE_DEF) return cmta_pkg::MAX_FACE_SIZE_DEF;
    return raw;
  endfunction

  // floor((c + m) * size / 2m), held below size, cut to the field width
  function automatic logic [cmta_pkg::TEXEL_W-1:0] texel_coord(longint c, longint m,
                                                              longint size);
    longint q;
    q = ((c + m) * size) / (2 * m);
    if (q > size - 1) q = size - 1;
    return cmta_pkg::TEXEL_W'(q);
  endfunction

  function automatic texel_res_t predict_texel(dir_t d);
    texel_res_t r;
    longint x, y, z, ax, ay, az, w, h;
    x  = d.x;
    y  = d.y;
    z  = d.z;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    w  = fit_size(width_reg);
    h  = fit_size(height_reg);
    r.zero = 1'b0;
    if (ax == 0 && ay == 0 && az == 0) begin
      r.face = cmta_pkg::FACE_ZN;
      r.tx   = '0;
      r.ty   = '0;
      r.zero = 1'b1;
    end else if (ax > ay && ax > az) begin
      r.face = (x > 0) ? cmta_pkg::FACE_XP : cmta_pkg::FACE_XN;
      r.tx   = texel_coord(z, ax, w);
      r.ty   = texel_coord(y, ax, h);
    end else if (ay > az) begin
      r.face = (y > 0) ? cmta_pkg::FACE_YP : cmta_pkg::FACE_YN;
      r.tx   = texel_coord(x, ay, w);
      r.ty   = texel_coord(z, ay, h);
    end else begin
      r.face = (z > 0) ? cmta_pkg::FACE_ZP : cmta_pkg::FACE_ZN;
      r.tx   = texel_coord(x, az, w);
      r.ty   = texel_coord(y, az, h);
    end
    return r;
  endfunction

  function automatic dir_t mk(int x, int y, int z);
    dir_t d;
    d.x = 16'(x);
    d.y = 16'(y);
    d.z = 16'(z);
    return d;
  endfunction

  // Magnitude m with a random sign; 32768 only fits as negative
  function automatic logic signed [15:0] with_sign(int m);
    if (m == 32768) return 16'sh8000;
    return $urandom_range(0, 1) ? 16'(m) : 16'(-m);
  endfunction

  // Mix of plain random vectors, ties, extremes and near-zero vectors
  function automatic dir_t rand_dir();
    dir_t d;
    int m;
    d.x = 16'($urandom);
    d.y = 16'($urandom);
    d.z = 16'($urandom);
    m   = $urandom_range(1, 32768);
    case ($urandom_range(0, 9))
      5: begin
        d.x = 16'($urandom_range(0, 8) - 4);
        d.y = 16'($urandom_range(0, 8) - 4);
        d.z = 16'($urandom_range(0, 8) - 4);
      end
      6: begin
        d.x = with_sign(m);
        d.y = with_sign(m);
        d.z = with_sign(m);
      end
      7: begin
        case ($urandom_range(0, 2))
          0: begin
            d.y = with_sign(m);
            d.z = with_sign(m);
            d.x = 16'($urandom_range(0, m) - m / 2);
          end
          1: begin
            d.x = with_sign(m);
            d.z = with_sign(m);
            d.y = 16'($urandom_range(0, m) - m / 2);
          end
          default: begin
            d.x = with_sign(m);
            d.y = with_sign(m);
            d.z = 16'($urandom_range(0, m) - m / 2);
          end
        endcase
      end
      8: begin
        case ($urandom_range(0, 2))
          0: d.x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          1: d.y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          default: d.z = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        endcase
      end
      9: begin
        if ($urandom_range(0, 2) == 0) d.x = '0;
        d.y = '0;
        d.z = '0;
      end
      default: ;
    endcase
    return d;
  endfunction

  // Write one size register and hold until the beat is taken
  task automatic write_size(cmta_pkg::cfg_reg_e idx, logic [cmta_pkg::SIZE_REG_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == cmta_pkg::CFG_FACE_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  // Drive direction beats from the pending queue; predict on each accepted beat
  always @(posedge clk) begin : drive_dir
    dir_t nxt;
    if (rst_n) begin
      if (dir_if.valid && dir_if.ready) begin
        texel_due.push_back(predict_texel('{dir_if.dir_x, dir_if.dir_y, dir_if.dir_z}));
        dir_beats <= dir_beats + 1;
      end
      if (!dir_if.valid || dir_if.ready) begin
        if (dir_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = dir_pending.pop_front();
          dir_if.valid <= 1'b1;
          dir_if.dir_x <= nxt.x;
          dir_if.dir_y <= nxt.y;
          dir_if.dir_z <= nxt.z;
        end else begin
          dir_if.valid <= 1'b0;
        end
      end
    end
  end

  // Start a long output stall at two points of the run
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((hold_next == 0 && dir_beats == 100) ||
                 (hold_next == 1 && dir_beats == 820)) begin
      hold_left <= HOLD_LEN;
      hold_next <= hold_next + 1;
    end
  end

  // Check each result beat against the oldest prediction; throttle ready
  always @(posedge clk) begin : watch_res
    texel_res_t want;
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        if (texel_due.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("result beat with nothing expected: face %0d x %0d y %0d zero %0d",
                     res_if.face, res_if.texel_x, res_if.texel_y, res_if.zero_dir);
        end else begin
          want = texel_due.pop_front();
          if (res_if.face !== want.face) note_mismatch("face", want.face, res_if.face);
          if (res_if.texel_x !== want.tx) note_mismatch("texel_x", want.tx, res_if.texel_x);
          if (res_if.texel_y !== want.ty) note_mismatch("texel_y", want.ty, res_if.texel_y);
          if (res_if.zero_dir !== want.zero)
            note_mismatch("zero_dir", want.zero, res_if.zero_dir);
        end
      end
      res_if.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("** cube_map_texel_address: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [cmta_pkg::SIZE_REG_W-1:0] w_set [6];
    logic [cmta_pkg::SIZE_REG_W-1:0] h_set [6];
    clk          = 1'b0;
    rst_n        = 1'b0;
    dir_if.valid = 1'b0;
    dir_if.dir_x = '0;
    dir_if.dir_y = '0;
    dir_if.dir_z = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = cmta_pkg::CFG_FACE_WIDTH;
    cfg_if.data  = '0;
    width_reg    = cmta_pkg::SIZE_RESET;
    height_reg   = cmta_pkg::SIZE_RESET;
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    dir_beats    = 0;
    hold_left    = 0;
    hold_next    = 0;
    err_cnt      = 0;
    cycles       = 0;

    // Size settings per phase; the first phase runs on reset values
    w_set = '{cmta_pkg::SIZE_RESET, 13'd0, 13'd8191, 13'd4097, 13'($urandom), 13'd1};
    h_set = '{cmta_pkg::SIZE_RESET, 13'd4096, 13'd1, 13'd300, 13'($urandom), 13'd0};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < 6; p++) begin
      if (p != 0) begin
        @(posedge clk);
        write_size(cmta_pkg::CFG_FACE_WIDTH, w_set[p]);
        write_size(cmta_pkg::CFG_FACE_HEIGHT, h_set[p]);
        cfg_if.valid <= 1'b0;
      end
      @(negedge clk);

      // Receiver slow first, then sender slow, then full rate
      if (p < 2) begin
        tx_idle_pct = 38;
        rx_idle_pct = 86;
      end else if (p < 4) begin
        tx_idle_pct = 86;
        rx_idle_pct = 38;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      if (p == 0) begin
        // Zero vector, axis extremes, ties and components equal to the major one
        dir_pending.push_back(mk(0, 0, 0));
        dir_pending.push_back(mk(32767, 0, 0));
        dir_pending.push_back(mk(-32768, 0, 0));
        dir_pending.push_back(mk(0, 32767, 0));
        dir_pending.push_back(mk(0, -32768, 0));
        dir_pending.push_back(mk(0, 0, 32767));
        dir_pending.push_back(mk(0, 0, -32768));
        dir_pending.push_back(mk(5, 5, 5));
        dir_pending.push_back(mk(5, 5, 3));
        dir_pending.push_back(mk(5, 3, 5));
        dir_pending.push_back(mk(-7, 7, 0));
        dir_pending.push_back(mk(100, 100, -100));
        dir_pending.push_back(mk(-32768, 32767, -32768));
        dir_pending.push_back(mk(-32768, -32768, -32768));
        dir_pending.push_back(mk(32767, 32767, 32767));
        dir_pending.push_back(mk(1, -1, -1));
        dir_pending.push_back(mk(-1, 0, 0));
        dir_pending.push_back(mk(32767, -32768, 32767));
        dir_pending.push_back(mk(3, -2, 1));
        dir_pending.push_back(mk(-1234, 20000, -19999));
        dir_pending.push_back(mk(0, 0, 1));
      end
      repeat (RAND_ITEMS) dir_pending.push_back(rand_dir());

      // Drain before touching the size registers again
      while (dir_pending.size() != 0 || dir_if.valid || texel_due.size() != 0)
        @(negedge clk);
      repeat (LAT_CYC) @(negedge clk);
    end

    repeat (2 * LAT_CYC) @(posedge clk);
    if (err_cnt == 0) begin
      $display("** cube_map_texel_address: PASSED **");
    end else begin
      $display("** cube_map_texel_address: FAILED **");
    end
    $finish;
  end

endmodule
